/* design/sorted_run_bucket_partitioner_macros.svh */
// assertion macros shared by the rtl
`ifndef SORTED_RUN_BUCKET_PARTITIONER_MACROS_SVH
`define SORTED_RUN_BUCKET_PARTITIONER_MACROS_SVH

// same-cycle implication, disabled during reset
`define SRBP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define SRBP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/srbp_pkg.sv */
`timescale 1ns / 1ps

package srbp_pkg;

  localparam int MaxItems  = 64;
  localparam int ValueBits = 8;
  localparam int ValueW    = 8;
  localparam int BucketW   = 6;

  typedef struct packed {
    logic signed [ValueW-1:0] value;
    logic                     last;
  } item_t;

  typedef struct packed {
    logic signed [ValueW-1:0] value_res;
    logic [BucketW-1:0]       bucket;
    logic                     bucket_end;
    logic                     last_res;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic load_wr;
    logic clear;
    logic scan;
    logic emit_init;
    logic emit;
    logic finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic item_last;
    logic sweep_last;
    logic emit_last;
    logic pipe_empty;
  } sts_t;

endpackage

/* design/srbp_ctrl.sv */
`timescale 1ns / 1ps
`include "sorted_run_bucket_partitioner_macros.svh"

module srbp_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  srbp_pkg::sts_t   sts_i,
  output srbp_pkg::cmd_t   cmd_o,
  output logic             busy_o
);

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StLoad,
    StScan,
    StScanTail,
    StEmit,
    StDrain
  } state_e;

  state_e state_q, state_d;
  logic   busy_q, busy_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      StClear: begin
        cmd_o.clear = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        cmd_o.accept = start_i & ~busy_q;
        if (start_i & ~busy_q) begin
          state_d = StLoad;
        end
      end
      StLoad: begin
        cmd_o.load_wr = 1'b1;
        state_d = sts_i.item_last ? StScan : StIdle;
      end
      StScan: begin
        cmd_o.scan = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = StScanTail;
        end
      end
      StScanTail: begin
        cmd_o.emit_init = 1'b1;
        state_d = StEmit;
      end
      StEmit: begin
        cmd_o.emit = 1'b1;
        if (sts_i.emit_last) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        if (sts_i.pipe_empty) begin
          cmd_o.finish = 1'b1;
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign busy_d = (state_d != StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      busy_q  <= 1'b1;
    end else begin
      state_q <= state_d;
      busy_q  <= busy_d;
    end
  end

  assign busy_o = busy_q;

  `SRBP_ASSERT_NEXT(a_accept_busy, cmd_o.accept, busy_q, "item accepted but not busy next")

endmodule

/* design/srbp_dpath.sv */
`timescale 1ns / 1ps
`include "sorted_run_bucket_partitioner_macros.svh"

module srbp_dpath #(
  parameter int MAX_ITEMS  = srbp_pkg::MaxItems,
  parameter int VALUE_BITS = srbp_pkg::ValueBits
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  srbp_pkg::cmd_t    cmd_i,
  input  srbp_pkg::item_t   item_i,
  output srbp_pkg::sts_t    sts_o,
  output srbp_pkg::result_t res_o,
  output logic              res_valid_o
);

  localparam int PW     = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CW     = $clog2(MAX_ITEMS + 1);
  localparam int Domain = 1 << VALUE_BITS;
  localparam int OW     = srbp_pkg::ValueW;
  localparam int BW     = srbp_pkg::BucketW;
  localparam logic [VALUE_BITS-1:0] SignBit = {1'b1, {(VALUE_BITS-1){1'b0}}};

  // memories
  logic [VALUE_BITS-1:0] item_mem  [MAX_ITEMS];
  logic                  seen_mem  [Domain];
  logic [PW-1:0]         first_mem [Domain];
  logic [PW-1:0]         last_mem  [Domain];
  logic [PW-1:0]         vb_mem    [Domain];
  logic [PW-1:0]         blast_mem [MAX_ITEMS];

  // input capture
  logic [VALUE_BITS+OW-1:0] in_ext;
  logic [VALUE_BITS-1:0]    in_raw, in_idx;
  logic [VALUE_BITS-1:0]    raw_q, idx_q;
  logic                     last_q;

  // counters
  logic [CW-1:0]         count_q, cnt_m1;
  logic [PW-1:0]         pos;
  logic                  room;
  logic [VALUE_BITS-1:0] d_q;

  // read data
  logic                  seen_rd_q;
  logic [PW-1:0]         first_rd_q, last_rd_q;
  logic [VALUE_BITS-1:0] item_rd_q;
  logic [PW-1:0]         vb_rd_q, blast_rd_q;

  // scan stage
  logic                  sv_q;
  logic [VALUE_BITS-1:0] sd_q;
  logic                  have_prev_q;
  logic [PW-1:0]         prev_last_q, nb_q, bmax_q;
  logic                  scan_hit, new_bkt;
  logic [PW-1:0]         nb_d, bmax_d;
  logic                  seen_we, seen_wd;
  logic [VALUE_BITS-1:0] seen_wa, seen_ra;

  // emission pipeline
  logic [PW-1:0]            i_q, b_q;
  logic                     v1_q, v2_q;
  logic [PW-1:0]            i1_q, b1_q, i2_q, b2_q;
  logic [VALUE_BITS-1:0]    item2_q;
  logic [CW-1:0]            k_q;
  logic                     i_end, match;
  logic [VALUE_BITS+OW-1:0] out_ext;
  logic [PW+BW-1:0]         bkt_ext;
  srbp_pkg::result_t        res_q;
  logic                     res_valid_q;

  assign in_ext = {{VALUE_BITS{1'b0}}, item_i.value};
  assign in_raw = in_ext[VALUE_BITS-1:0];
  assign in_idx = in_raw ^ SignBit;

  assign room   = (count_q < CW'(MAX_ITEMS));
  assign pos    = count_q[PW-1:0];
  assign cnt_m1 = count_q - CW'(1);

  // bucket tracking over present values in ascending order
  assign scan_hit = sv_q & seen_rd_q;
  assign new_bkt  = have_prev_q & (first_rd_q < prev_last_q);
  assign nb_d     = nb_q + PW'(new_bkt);
  assign bmax_d   = (new_bkt | ~have_prev_q) ? last_rd_q :
                    ((last_rd_q > bmax_q) ? last_rd_q : bmax_q);

  assign seen_we = cmd_i.clear | cmd_i.scan | (cmd_i.load_wr & room);
  assign seen_wa = cmd_i.load_wr ? idx_q : d_q;
  assign seen_wd = cmd_i.load_wr;
  assign seen_ra = cmd_i.accept ? in_idx : d_q;

  assign i_end   = (CW'(i_q) == cnt_m1);
  assign match   = v2_q & (vb_rd_q == b2_q);
  assign out_ext = {{OW{item2_q[VALUE_BITS-1]}}, item2_q};
  assign bkt_ext = {{BW{1'b0}}, b2_q};

  assign sts_o.item_last  = last_q;
  assign sts_o.sweep_last = (d_q == {VALUE_BITS{1'b1}});
  assign sts_o.emit_last  = i_end & (b_q == nb_q);
  assign sts_o.pipe_empty = ~v1_q & ~v2_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_wr & room) begin
      item_mem[pos] <= raw_q;
    end
    item_rd_q <= item_mem[i_q];
  end

  always_ff @(posedge clk_i) begin
    if (seen_we) begin
      seen_mem[seen_wa] <= seen_wd;
    end
    seen_rd_q <= seen_mem[seen_ra];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_wr & room & ~seen_rd_q) begin
      first_mem[idx_q] <= pos;
    end
    first_rd_q <= first_mem[d_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_wr & room) begin
      last_mem[idx_q] <= pos;
    end
    last_rd_q <= last_mem[d_q];
  end

  always_ff @(posedge clk_i) begin
    if (scan_hit) begin
      vb_mem[sd_q] <= nb_d;
    end
    vb_rd_q <= vb_mem[item_rd_q ^ SignBit];
  end

  always_ff @(posedge clk_i) begin
    if (scan_hit) begin
      blast_mem[nb_d] <= bmax_d;
    end
    blast_rd_q <= blast_mem[b1_q];
  end

  // payload pipeline
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      raw_q <= in_raw;
      idx_q <= in_idx;
    end
    sd_q    <= d_q;
    i1_q    <= i_q;
    b1_q    <= b_q;
    i2_q    <= i1_q;
    b2_q    <= b1_q;
    item2_q <= item_rd_q;
    if (match) begin
      res_q.value_res  <= $signed(out_ext[OW-1:0]);
      res_q.bucket     <= bkt_ext[BW-1:0];
      res_q.bucket_end <= (i2_q == blast_rd_q);
      res_q.last_res   <= (k_q == cnt_m1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q      <= 1'b0;
      count_q     <= '0;
      d_q         <= '0;
      sv_q        <= 1'b0;
      have_prev_q <= 1'b0;
      prev_last_q <= '0;
      nb_q        <= '0;
      bmax_q      <= '0;
      i_q         <= '0;
      b_q         <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      k_q         <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        last_q <= item_i.last;
      end
      if (cmd_i.load_wr) begin
        if (room) begin
          count_q <= count_q + CW'(1);
        end
        have_prev_q <= 1'b0;
        nb_q        <= '0;
        bmax_q      <= '0;
      end
      if (cmd_i.clear | cmd_i.scan) begin
        d_q <= d_q + VALUE_BITS'(1);
      end
      sv_q <= cmd_i.scan;
      if (scan_hit) begin
        have_prev_q <= 1'b1;
        prev_last_q <= last_rd_q;
        nb_q        <= nb_d;
        bmax_q      <= bmax_d;
      end
      if (cmd_i.emit_init) begin
        i_q <= '0;
        b_q <= '0;
      end else if (cmd_i.emit) begin
        if (i_end) begin
          i_q <= '0;
          b_q <= b_q + PW'(1);
        end else begin
          i_q <= i_q + PW'(1);
        end
      end
      v1_q <= cmd_i.emit;
      v2_q <= v1_q;
      if (cmd_i.finish) begin
        count_q <= '0;
        k_q     <= '0;
      end else if (match) begin
        k_q <= k_q + CW'(1);
      end
      res_valid_q <= match;
    end
  end

  assign res_o       = res_q;
  assign res_valid_o = res_valid_q;

  `SRBP_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CW'(MAX_ITEMS), "item count beyond store depth")
  `SRBP_ASSERT_NOW(a_emit_bound, match, k_q < count_q, "more results than stored items")

endmodule

/* design/sorted_run_bucket_partitioner.sv */
`timescale 1ns / 1ps
`include "sorted_run_bucket_partitioner_macros.svh"

// Loads a set of signed values, one item per start pulse, and on the item marked last emits
// every stored value grouped by bucket, one result per strobe on res_valid_o. The receiver
// cannot stall: each result is shown for exactly one cycle. After reset the block is busy while
// it clears its value table. Each loaded item keeps busy high while the table is updated
// (load state), so a new item is not taken before the last one is written. The last
// item then starts a sweep over the value domain, after which one store read is issued
// per cycle for each bucket and each stored item, followed by a pipeline drain; results
// of a bucket come out as its items are found. The value-domain sweep and the per-bucket passes
// over the item store set the set latency.
module sorted_run_bucket_partitioner #(
  parameter int MAX_ITEMS  = srbp_pkg::MaxItems,
  parameter int VALUE_BITS = srbp_pkg::ValueBits
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  srbp_pkg::item_t   item_i,
  output srbp_pkg::result_t res_o,
  output logic              res_valid_o
);

  srbp_pkg::cmd_t cmd;
  srbp_pkg::sts_t sts;

  srbp_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  srbp_dpath #(
    .MAX_ITEMS  (MAX_ITEMS),
    .VALUE_BITS (VALUE_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .item_i      (item_i),
    .sts_o       (sts),
    .res_o       (res_o),
    .res_valid_o (res_valid_o)
  );

  `SRBP_ASSERT_NOW(a_result_while_busy, res_valid_o, busy, "result strobe while idle")

endmodule
